[rtl/bsmm_pkg.sv]
// shared types and constants for the bit string segment mix block
package bsmm_pkg;

  localparam int MAX_BITS_DEF    = 256;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int IDX_W           = 8;
  localparam int LEN_W           = 9;
  localparam int DRAW_W          = 9;
  localparam logic [LEN_W-1:0] STR_LEN_RST = 9'd64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_MIX   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LEN_ONE = 3'd1,
    ST_EQUAL   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_DRAW    = 3'd4,
    ST_NO_SEG  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_COUNT
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e              op;
    status_e          status;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             bit_value;
    logic [DRAW_W-1:0] draw;
  } cmd_t;

  // back-end status seen by the front
  typedef struct packed {
    logic clearing;
    logic queue_full;
  } flow_t;

endpackage

[rtl/bitstring_segment_mix_mutation_top.sv]
// top level of the bit string segment mix block
// a beat is registered in the command queue, then taken by the back end from idle;
//   writes and refused read or start beats report from idle, reads and mixes via the
//   read state, a segment start after the count walk over the segment
// the back end takes a new command only when it is back in idle
// reset: after rst_ni the bit store is cleared one bit a cycle with busy high;
//   the result strobe is never stalled by the receiver
module bitstring_segment_mix_mutation_top #(
  parameter int MAX_BITS    = bsmm_pkg::MAX_BITS_DEF,
  parameter int QUEUE_DEPTH = bsmm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command beat
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic [bsmm_pkg::IDX_W-1:0]   index_a_i,
  input  logic [bsmm_pkg::IDX_W-1:0]   index_b_i,
  input  logic                         bit_value_i,
  input  logic [bsmm_pkg::DRAW_W-1:0]  draw_i,
  // string length register
  input  logic                         cfg_we_i,
  input  logic [bsmm_pkg::LEN_W-1:0]   cfg_wdata_i,
  // result beat, one cycle per strobe
  output logic                         done_o,
  output logic                         bit_out_o,
  output logic [bsmm_pkg::IDX_W-1:0]   bit_index_o,
  output logic [2:0]                   status_o,
  output logic                         last_o
);

  logic [bsmm_pkg::LEN_W-1:0] string_length_q;
  bsmm_pkg::flow_t            flow;
  bsmm_pkg::cmd_t             push_cmd;
  bsmm_pkg::cmd_t             head_cmd;
  bsmm_pkg::status_e          status;
  logic                       push;
  logic                       pop;
  logic                       empty;
  logic                       full;
  logic                       clearing;

  // configuration should only change while the block is idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      string_length_q <= bsmm_pkg::STR_LEN_RST;
    end else if (cfg_we_i) begin
      string_length_q <= cfg_wdata_i;
    end
  end

  assign flow.clearing   = clearing;
  assign flow.queue_full = full;

  // front: takes the beat, checks index ranges and orders segment bounds
  bsmm_front #(
    .MAX_BITS(MAX_BITS)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .index_a_i      (index_a_i),
    .index_b_i      (index_b_i),
    .bit_value_i    (bit_value_i),
    .draw_i         (draw_i),
    .string_length_i(string_length_q),
    .flow_i         (flow),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // queue lets the front keep taking beats while the back walks a segment
  bsmm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .empty_o(empty),
    .full_o (full)
  );

  // back: owns the bit store and the segment state, issues every result
  bsmm_back #(
    .MAX_BITS(MAX_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .bit_out_o  (bit_out_o),
    .bit_index_o(bit_index_o),
    .status_o   (status),
    .last_o     (last_o)
  );

  assign status_o = status;

endmodule

[rtl/bsmm_front.sv]
// front end: accepts beats, range-checks them and orders the segment bounds
module bsmm_front #(
  parameter int MAX_BITS = bsmm_pkg::MAX_BITS_DEF
) (
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic [bsmm_pkg::IDX_W-1:0]   index_a_i,
  input  logic [bsmm_pkg::IDX_W-1:0]   index_b_i,
  input  logic                         bit_value_i,
  input  logic [bsmm_pkg::DRAW_W-1:0]  draw_i,
  input  logic [bsmm_pkg::LEN_W-1:0]   string_length_i,
  input  bsmm_pkg::flow_t              flow_i,
  output logic                         push_o,
  output bsmm_pkg::cmd_t               cmd_o
);

  localparam int LW = $clog2(MAX_BITS + 1);
  localparam int CW = (LW > bsmm_pkg::LEN_W) ? LW : bsmm_pkg::LEN_W;

  logic [CW-1:0] sl_w;
  logic [CW-1:0] max_w;
  logic [CW-1:0] len;
  logic          a_bad;
  logic          b_bad;
  bsmm_pkg::op_e op;

  assign busy   = flow_i.clearing | flow_i.queue_full;
  assign push_o = start & ~busy;

  // effective length is the register clamped to the store size
  assign sl_w  = CW'(string_length_i);
  assign max_w = CW'(MAX_BITS);
  assign len   = (sl_w > max_w) ? max_w : sl_w;
  assign a_bad = CW'(index_a_i) >= len;
  assign b_bad = CW'(index_b_i) >= len;
  assign op    = bsmm_pkg::op_e'(operation_i);

  always_comb begin
    cmd_o.op        = op;
    cmd_o.status    = bsmm_pkg::ST_OK;
    cmd_o.lo        = index_a_i;
    cmd_o.hi        = index_b_i;
    cmd_o.bit_value = bit_value_i;
    cmd_o.draw      = draw_i;
    case (op)
      bsmm_pkg::OP_WRITE, bsmm_pkg::OP_READ: begin
        if (a_bad) cmd_o.status = bsmm_pkg::ST_RANGE;
      end
      bsmm_pkg::OP_START: begin
        if (index_b_i < index_a_i) begin
          cmd_o.lo = index_b_i;
          cmd_o.hi = index_a_i;
        end
        if (len < CW'(2)) begin
          cmd_o.status = bsmm_pkg::ST_LEN_ONE;
        end else if (a_bad || b_bad) begin
          cmd_o.status = bsmm_pkg::ST_RANGE;
        end else if (index_a_i == index_b_i) begin
          cmd_o.status = bsmm_pkg::ST_EQUAL;
        end
      end
      default: begin
        // mix checks depend on segment state, done in the back end
        cmd_o.status = bsmm_pkg::ST_OK;
      end
    endcase
  end

endmodule

[rtl/bsmm_queue.sv]
// small command queue between front and back end
module bsmm_queue #(
  parameter int DEPTH = bsmm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsmm_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output bsmm_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  bsmm_pkg::cmd_t entry_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]  count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == NW'(DEPTH);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    if (do_push && !do_pop) count_d = count_q + NW'(1);
    if (do_pop && !do_push) count_d = count_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

[rtl/bsmm_back.sv]
// back end: bit store, segment counters and the mix sequencer
module bsmm_back #(
  parameter int MAX_BITS = bsmm_pkg::MAX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsmm_pkg::cmd_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        done_o,
  output logic                        bit_out_o,
  output logic [bsmm_pkg::IDX_W-1:0]  bit_index_o,
  output bsmm_pkg::status_e           status_o,
  output logic                        last_o
);

  localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int IW = bsmm_pkg::IDX_W;
  localparam int LW = bsmm_pkg::LEN_W;

  logic mem [MAX_BITS];
  logic rd_q;

  bsmm_pkg::back_state_e state_q, state_d;
  bsmm_pkg::cmd_t        cmd_q, cmd_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [IW-1:0]         ptr_q, ptr_d;
  logic                  issued_q, issued_d;
  logic                  pend_q, pend_d;
  logic [LW-1:0]         ones_left_q, ones_left_d;
  logic [LW-1:0]         zeros_left_q, zeros_left_d;
  logic [LW-1:0]         ones_weight_q, ones_weight_d;
  logic [LW-1:0]         seg_len_q, seg_len_d;
  logic [IW-1:0]         cursor_q, cursor_d;
  logic [IW-1:0]         end_q, end_d;
  logic                  active_q, active_d;
  logic                  done_q, done_d;
  logic                  bit_q, bit_d;
  logic [IW-1:0]         idx_q, idx_d;
  bsmm_pkg::status_e     stat_q, stat_d;
  logic                  last_q, last_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          want_one;
  logic          new_bit;

  assign clearing_o  = state_q == bsmm_pkg::BK_CLEAR;
  assign done_o      = done_q;
  assign bit_out_o   = bit_q;
  assign bit_index_o = idx_q;
  assign status_o    = stat_q;
  assign last_o      = last_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bsmm_pkg::BK_CLEAR: begin
        if (clr_q == AW'(MAX_BITS - 1)) state_d = bsmm_pkg::BK_IDLE;
      end
      bsmm_pkg::BK_IDLE: begin
        if (!empty_i) begin
          case (head_i.op)
            bsmm_pkg::OP_READ: begin
              if (head_i.status == bsmm_pkg::ST_OK) state_d = bsmm_pkg::BK_READ;
            end
            bsmm_pkg::OP_START: begin
              if (head_i.status == bsmm_pkg::ST_OK) state_d = bsmm_pkg::BK_COUNT;
            end
            bsmm_pkg::OP_MIX: state_d = bsmm_pkg::BK_READ;
            default:          state_d = bsmm_pkg::BK_IDLE;
          endcase
        end
      end
      bsmm_pkg::BK_READ: state_d = bsmm_pkg::BK_IDLE;
      bsmm_pkg::BK_COUNT: begin
        if (pend_q && issued_q) state_d = bsmm_pkg::BK_IDLE;
      end
      default: state_d = bsmm_pkg::BK_IDLE;
    endcase
  end

  // mix decision: draw against the start-time ones count, then respect what is left
  assign want_one = cmd_q.draw <= ones_weight_q;
  always_comb begin
    if (want_one) new_bit = ones_left_q != '0;
    else          new_bit = zeros_left_q == '0;
  end

  // datapath and outputs
  always_comb begin
    pop_o         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_q;
    mem_wdata     = 1'b0;
    mem_raddr     = AW'(cursor_q);
    cmd_d         = cmd_q;
    clr_d         = clr_q;
    ptr_d         = ptr_q;
    issued_d      = issued_q;
    pend_d        = 1'b0;
    ones_left_d   = ones_left_q;
    zeros_left_d  = zeros_left_q;
    ones_weight_d = ones_weight_q;
    seg_len_d     = seg_len_q;
    cursor_d      = cursor_q;
    end_d         = end_q;
    active_d      = active_q;
    done_d        = 1'b0;
    bit_d         = 1'b0;
    idx_d         = '0;
    stat_d        = bsmm_pkg::ST_OK;
    last_d        = 1'b0;
    case (state_q)
      bsmm_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
      end
      bsmm_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          case (head_i.op)
            bsmm_pkg::OP_WRITE: begin
              done_d = 1'b1;
              stat_d = head_i.status;
              if (head_i.status == bsmm_pkg::ST_OK) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(head_i.lo);
                mem_wdata = head_i.bit_value;
                bit_d     = head_i.bit_value;
                idx_d     = head_i.lo;
              end
            end
            bsmm_pkg::OP_READ: begin
              mem_raddr = AW'(head_i.lo);
              if (head_i.status != bsmm_pkg::ST_OK) begin
                done_d = 1'b1;
                stat_d = head_i.status;
              end
            end
            bsmm_pkg::OP_START: begin
              if (head_i.status != bsmm_pkg::ST_OK) begin
                done_d = 1'b1;
                stat_d = head_i.status;
              end else begin
                ptr_d        = head_i.lo;
                issued_d     = 1'b0;
                ones_left_d  = '0;
                zeros_left_d = '0;
                cursor_d     = head_i.lo;
                end_d        = head_i.hi;
                active_d     = 1'b1;
                seg_len_d    = LW'(head_i.hi) - LW'(head_i.lo) + LW'(1);
              end
            end
            default: begin
              mem_raddr = AW'(cursor_q);
            end
          endcase
        end
      end
      bsmm_pkg::BK_READ: begin
        done_d = 1'b1;
        if (cmd_q.op == bsmm_pkg::OP_READ) begin
          bit_d = rd_q;
          idx_d = cmd_q.lo;
        end else if (!active_q) begin
          stat_d = bsmm_pkg::ST_NO_SEG;
        end else if (cmd_q.draw == '0 || cmd_q.draw > seg_len_q) begin
          stat_d = bsmm_pkg::ST_DRAW;
          bit_d  = rd_q;
          idx_d  = cursor_q;
        end else begin
          if (new_bit) begin
            if (ones_left_q != '0) ones_left_d = ones_left_q - LW'(1);
          end else begin
            if (zeros_left_q != '0) zeros_left_d = zeros_left_q - LW'(1);
          end
          mem_we    = 1'b1;
          mem_waddr = AW'(cursor_q);
          mem_wdata = new_bit;
          bit_d     = new_bit;
          idx_d     = cursor_q;
          if (cursor_q == end_q) begin
            active_d = 1'b0;
            last_d   = 1'b1;
          end else begin
            cursor_d = cursor_q + IW'(1);
          end
        end
      end
      bsmm_pkg::BK_COUNT: begin
        // one read issued per cycle, its data counted in the following cycle
        if (!issued_q) begin
          mem_raddr = AW'(ptr_q);
          pend_d    = 1'b1;
          if (ptr_q == cmd_q.hi) issued_d = 1'b1;
          else                   ptr_d    = ptr_q + IW'(1);
        end
        if (pend_q) begin
          ones_left_d  = ones_left_q + LW'(rd_q);
          zeros_left_d = zeros_left_q + LW'(!rd_q);
          if (issued_q) begin
            ones_weight_d = ones_left_q + LW'(rd_q);
            done_d        = 1'b1;
            idx_d         = cmd_q.lo;
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bsmm_pkg::BK_CLEAR;
      clr_q         <= '0;
      issued_q      <= 1'b0;
      pend_q        <= 1'b0;
      ones_left_q   <= '0;
      zeros_left_q  <= '0;
      ones_weight_q <= '0;
      seg_len_q     <= '0;
      cursor_q      <= '0;
      end_q         <= '0;
      active_q      <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      issued_q      <= issued_d;
      pend_q        <= pend_d;
      ones_left_q   <= ones_left_d;
      zeros_left_q  <= zeros_left_d;
      ones_weight_q <= ones_weight_d;
      seg_len_q     <= seg_len_d;
      cursor_q      <= cursor_d;
      end_q         <= end_d;
      active_q      <= active_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ptr_q  <= ptr_d;
    bit_q  <= bit_d;
    idx_q  <= idx_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bsmm_pkg::BK_IDLE) |-> !pop_o)
    else $error("command popped outside idle");

  a_counts_match_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && state_q != bsmm_pkg::BK_COUNT) |->
      ({1'b0, ones_left_q} + {1'b0, zeros_left_q}) ==
      ({2'b0, end_q} - {2'b0, cursor_q} + 10'd1))
    else $error("segment counts disagree with bits left");

  a_no_result_from_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) != bsmm_pkg::BK_CLEAR)
    else $error("result during clearing pass");

  a_last_is_ok_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> (done_q && stat_q == bsmm_pkg::ST_OK && !active_q))
    else $error("last flag on a bad result");
`endif

endmodule
